// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/bsc_pkg.sv =====
package bsc_pkg;

  localparam int MAX_PROCS  = 16;
  localparam int MAX_RES    = 8;
  localparam int COUNT_BITS = 8;

  localparam int PROC_W  = $clog2(MAX_PROCS);
  localparam int RES_W   = $clog2(MAX_RES);
  localparam int ADDR_W  = PROC_W + RES_W;
  localparam int PCNT_W  = PROC_W + 1;
  localparam int ACC_W   = COUNT_BITS + PROC_W;
  localparam int AVAIL_W = ACC_W + 1;

  localparam int NRES_CFG_W  = 4;
  localparam int NPROC_CFG_W = 5;
  localparam int CFG_W       = 5;

  localparam logic [1:0] CMD_LOAD_TOTAL = 2'd0;
  localparam logic [1:0] CMD_LOAD_PROC  = 2'd1;
  localparam logic [1:0] CMD_CHECK      = 2'd2;

  localparam logic CFG_NUM_RES  = 1'b0;
  localparam logic CFG_NUM_PROC = 1'b1;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [3:0]            proc_index;
    logic [2:0]            res_index;
    logic [COUNT_BITS-1:0] total_count;
    logic [COUNT_BITS-1:0] alloc_count;
    logic [COUNT_BITS-1:0] max_count;
  } in_t;

  typedef struct packed {
    logic [3:0] proc_id;
    logic       safe;
    logic       last;
  } out_t;

  typedef struct packed {
    logic ld_total;
    logic ld_proc;
    logic sum_init;
    logic sum_step;
    logic pend_init;
    logic pass_init;
    logic proc_load;
    logic fit_step;
    logic decide;
    logic rel_step;
    logic next_step;
    logic emit_unsafe;
    logic addr_proc;
  } ctl_t;

  typedef struct packed {
    logic sum_last;
    logic j_last;
    logic i_last;
    logic fits;
    logic progress;
    logic kept_zero;
  } sts_t;

endpackage

// ===== rtl/core/bankers_safety_check.sv =====
// Banker's algorithm safety check.
// Transactions enter on start/in_i while busy is low. Command LOAD_TOTAL
// writes a resource total, LOAD_PROC writes one allocation/claim pair;
// both leave busy low and give no result. CHECK raises busy and walks the
// stored matrices; busy stays high until the last result is produced.
// Results appear on result_o with out_strobe_o high for one cycle, in the
// cycle after they are found; the receiver cannot stall. A safe state
// gives every process in completion order, last set on the final one; an
// unsafe state gives the completed processes, then proc_id 0, safe 0, last 1.
// CHECK first sums each resource's allocations over the processes in use,
// then runs passes: each pending process gets a fit test against the
// availability and, if it fits, releases its allocation before advancing.
// Every matrix element is read through the single registered read port of
// the allocation/claim memory.
// Configuration writes (cfg_we_i) take effect at once; write only when idle.
// Reset returns to idle with both counts at one; the stores are undefined
// until loaded.
module bankers_safety_check import bsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  in_t              in_i,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output logic             out_strobe_o,
  output out_t             result_o
);

  `include "assert_macros.svh"

  ctl_t ctl;
  sts_t sts;

  bsc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (in_i.cmd),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy   (busy)
  );

  bsc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .out_strobe_o (out_strobe_o),
    .result_o     (result_o)
  );

  `ASSERT_IMPLIES(a_unsafe_is_last, clk_i, rst_ni, out_strobe_o && !result_o.safe, result_o.last)
  `ASSERT_IMPLIES(a_unsafe_id_zero, clk_i, rst_ni, out_strobe_o && !result_o.safe, result_o.proc_id == '0)
  `ASSERT_NEXT(a_check_goes_busy, clk_i, rst_ni, start && !busy && in_i.cmd == CMD_CHECK, busy)
  `ASSERT_NEXT(a_nothing_after_last, clk_i, rst_ni, out_strobe_o && result_o.last, !out_strobe_o)

endmodule

// ===== rtl/core/bsc_datapath.sv =====
module bsc_datapath import bsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  in_t              in_i,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  ctl_t             ctl_i,
  output sts_t             sts_o,
  output logic             out_strobe_o,
  output out_t             result_o
);

  logic [2*COUNT_BITS-1:0]   pair_mem [MAX_PROCS*MAX_RES];
  logic [2*COUNT_BITS-1:0]   rd_q;
  logic [COUNT_BITS-1:0]     total_q [MAX_RES];
  logic signed [AVAIL_W-1:0] avail_q [MAX_RES];
  logic [PROC_W-1:0]         pending_q [MAX_PROCS];

  logic [RES_W-1:0]  nr_last_q, nr_last_d;
  logic [PROC_W-1:0] np_last_q, np_last_d;
  logic [PROC_W-1:0] i_q, p_q;
  logic [RES_W-1:0]  j_q;
  logic [PCNT_W-1:0] kept_q, pcount_q;
  logic [ACC_W-1:0]  acc_q;
  logic              fits_q, progress_q, strobe_q;
  out_t              result_q, result_d;

  logic [ADDR_W-1:0]         rd_addr;
  logic [COUNT_BITS-1:0]     alloc_rd, claim_rd;
  logic [ACC_W-1:0]          acc_sum;
  logic signed [AVAIL_W-1:0] need, cur_avail;
  logic                      need_gt, emit, i_last, kept_zero;
  logic [NRES_CFG_W-1:0]     nr_raw;
  logic [NPROC_CFG_W-1:0]    np_raw;

  assign alloc_rd  = rd_q[2*COUNT_BITS-1:COUNT_BITS];
  assign claim_rd  = rd_q[COUNT_BITS-1:0];
  assign rd_addr   = ctl_i.addr_proc ? {p_q, j_q} : {i_q, j_q};
  assign acc_sum   = acc_q + {{PROC_W{1'b0}}, alloc_rd};
  assign cur_avail = avail_q[j_q];
  assign need      = $signed({{(AVAIL_W-COUNT_BITS){1'b0}}, claim_rd})
                   - $signed({{(AVAIL_W-COUNT_BITS){1'b0}}, alloc_rd});
  assign need_gt   = need > cur_avail;
  assign i_last    = ({1'b0, i_q} == (pcount_q - PCNT_W'(1)));
  assign kept_zero = (kept_q == '0);

  assign nr_raw = cfg_data_i[NRES_CFG_W-1:0];
  assign np_raw = cfg_data_i[NPROC_CFG_W-1:0];

  always_comb begin
    nr_last_d = nr_last_q;
    np_last_d = np_last_q;
    if (nr_raw == '0) begin
      nr_last_d = '0;
    end else if (nr_raw > NRES_CFG_W'(MAX_RES)) begin
      nr_last_d = RES_W'(MAX_RES - 1);
    end else begin
      nr_last_d = RES_W'(nr_raw - NRES_CFG_W'(1));
    end
    if (np_raw == '0) begin
      np_last_d = '0;
    end else if (np_raw > NPROC_CFG_W'(MAX_PROCS)) begin
      np_last_d = PROC_W'(MAX_PROCS - 1);
    end else begin
      np_last_d = PROC_W'(np_raw - NPROC_CFG_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nr_last_q <= '0;
      np_last_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_NUM_RES) begin
        nr_last_q <= nr_last_d;
      end else begin
        np_last_q <= np_last_d;
      end
    end
  end

  // allocation/claim pair memory, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_proc) begin
      pair_mem[{in_i.proc_index, in_i.res_index}] <= {in_i.alloc_count, in_i.max_count};
    end
    rd_q <= pair_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_total) begin
      total_q[in_i.res_index] <= in_i.total_count;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_init) begin
      i_q   <= '0;
      j_q   <= '0;
      acc_q <= '0;
    end
    if (ctl_i.sum_step) begin
      if (i_q == np_last_q) begin
        avail_q[j_q] <= $signed({{(AVAIL_W-COUNT_BITS){1'b0}}, total_q[j_q]})
                      - $signed({1'b0, acc_sum});
        acc_q <= '0;
        i_q   <= '0;
        j_q   <= j_q + RES_W'(1);
      end else begin
        acc_q <= acc_sum;
        i_q   <= i_q + PROC_W'(1);
      end
    end
    if (ctl_i.pend_init) begin
      for (int k = 0; k < MAX_PROCS; k++) begin
        pending_q[k] <= PROC_W'(k);
      end
      pcount_q <= {1'b0, np_last_q} + PCNT_W'(1);
    end
    if (ctl_i.pass_init) begin
      i_q        <= '0;
      kept_q     <= '0;
      progress_q <= 1'b0;
    end
    if (ctl_i.proc_load) begin
      p_q    <= pending_q[i_q];
      j_q    <= '0;
      fits_q <= 1'b1;
    end
    if (ctl_i.fit_step) begin
      if (need_gt) begin
        fits_q <= 1'b0;
      end
      j_q <= j_q + RES_W'(1);
    end
    if (ctl_i.decide) begin
      j_q <= '0;
      if (fits_q) begin
        progress_q <= 1'b1;
      end else begin
        pending_q[kept_q[PROC_W-1:0]] <= p_q;
        kept_q <= kept_q + PCNT_W'(1);
      end
    end
    if (ctl_i.rel_step) begin
      avail_q[j_q] <= cur_avail + $signed({{(AVAIL_W-COUNT_BITS){1'b0}}, alloc_rd});
      j_q <= j_q + RES_W'(1);
    end
    if (ctl_i.next_step) begin
      if (i_last) begin
        pcount_q <= kept_q;
      end else begin
        i_q <= i_q + PROC_W'(1);
      end
    end
  end

  assign emit = (ctl_i.decide && fits_q) || ctl_i.emit_unsafe;

  always_comb begin
    if (ctl_i.emit_unsafe) begin
      result_d.proc_id = '0;
      result_d.safe    = 1'b0;
      result_d.last    = 1'b1;
    end else begin
      result_d.proc_id = p_q;
      result_d.safe    = 1'b1;
      result_d.last    = i_last && kept_zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      result_q <= result_d;
    end
  end

  assign out_strobe_o = strobe_q;
  assign result_o     = result_q;

  assign sts_o.sum_last  = (i_q == np_last_q);
  assign sts_o.j_last    = (j_q == nr_last_q);
  assign sts_o.i_last    = i_last;
  assign sts_o.fits      = fits_q;
  assign sts_o.progress  = progress_q;
  assign sts_o.kept_zero = kept_zero;

endmodule

// ===== rtl/core/bsc_ctrl.sv =====
module bsc_ctrl import bsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] cmd_i,
  input  sts_t       sts_i,
  output ctl_t       ctl_o,
  output logic       busy
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_SUM_RD     = 4'd1;
  localparam logic [3:0] S_SUM_ACC    = 4'd2;
  localparam logic [3:0] S_PASS_START = 4'd3;
  localparam logic [3:0] S_PROC_START = 4'd4;
  localparam logic [3:0] S_FIT_RD     = 4'd5;
  localparam logic [3:0] S_FIT_CMP    = 4'd6;
  localparam logic [3:0] S_DECIDE     = 4'd7;
  localparam logic [3:0] S_REL_RD     = 4'd8;
  localparam logic [3:0] S_REL_ADD    = 4'd9;
  localparam logic [3:0] S_NEXT       = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd_i)
            CMD_LOAD_TOTAL: ctl_o.ld_total = 1'b1;
            CMD_LOAD_PROC:  ctl_o.ld_proc  = 1'b1;
            CMD_CHECK: begin
              ctl_o.sum_init = 1'b1;
              state_d        = S_SUM_RD;
            end
            default: ;
          endcase
        end
      end
      S_SUM_RD: state_d = S_SUM_ACC;
      S_SUM_ACC: begin
        ctl_o.sum_step = 1'b1;
        if (sts_i.sum_last && sts_i.j_last) begin
          ctl_o.pend_init = 1'b1;
          state_d         = S_PASS_START;
        end else begin
          state_d = S_SUM_RD;
        end
      end
      S_PASS_START: begin
        ctl_o.pass_init = 1'b1;
        state_d         = S_PROC_START;
      end
      S_PROC_START: begin
        ctl_o.proc_load = 1'b1;
        state_d         = S_FIT_RD;
      end
      S_FIT_RD: begin
        ctl_o.addr_proc = 1'b1;
        state_d         = S_FIT_CMP;
      end
      S_FIT_CMP: begin
        ctl_o.fit_step = 1'b1;
        state_d        = sts_i.j_last ? S_DECIDE : S_FIT_RD;
      end
      S_DECIDE: begin
        ctl_o.decide = 1'b1;
        state_d      = sts_i.fits ? S_REL_RD : S_NEXT;
      end
      S_REL_RD: begin
        ctl_o.addr_proc = 1'b1;
        state_d         = S_REL_ADD;
      end
      S_REL_ADD: begin
        ctl_o.rel_step = 1'b1;
        state_d        = sts_i.j_last ? S_NEXT : S_REL_RD;
      end
      S_NEXT: begin
        ctl_o.next_step = 1'b1;
        if (sts_i.i_last) begin
          if (!sts_i.progress) begin
            ctl_o.emit_unsafe = 1'b1;
            state_d           = S_IDLE;
          end else if (sts_i.kept_zero) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_PASS_START;
          end
        end else begin
          state_d = S_PROC_START;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bsc_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;

  class safety_scoreboard;
    logic [COUNT_BITS-1:0] total_m [MAX_RES];
    logic [COUNT_BITS-1:0] alloc_m [MAX_PROCS][MAX_RES];
    logic [COUNT_BITS-1:0] claim_m [MAX_PROCS][MAX_RES];
    bit total_ok [MAX_RES];
    bit entry_ok [MAX_PROCS][MAX_RES];
    int nres = 1;
    int nproc = 1;
    out_t order_q[$];
    int errors = 0;
    int checks = 0;
    int unsafe_checks = 0;
    int compared = 0;

    function void set_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
      int v;
      if (idx == CFG_NUM_RES) begin
        v = int'(val[NRES_CFG_W-1:0]);
        nres = (v == 0) ? 1 : (v > MAX_RES) ? MAX_RES : v;
      end else begin
        v = int'(val[NPROC_CFG_W-1:0]);
        nproc = (v == 0) ? 1 : (v > MAX_PROCS) ? MAX_PROCS : v;
      end
    endfunction

    function int pending();
      return order_q.size();
    endfunction

    // Build the completion order for the current stores and queue it.
    function void find_safe_order();
      int avail [MAX_RES];
      int pend[$];
      int kept[$];
      out_t found[$];
      out_t r;
      bit moved;
      bit fits;
      int p;
      int need;
      for (int j = 0; j < nres; j++) begin
        avail[j] = int'(total_m[j]);
        for (int i = 0; i < nproc; i++) avail[j] -= int'(alloc_m[i][j]);
      end
      for (int i = 0; i < nproc; i++) pend.push_back(i);
      checks++;
      while (pend.size() > 0) begin
        kept.delete();
        moved = 1'b0;
        foreach (pend[k]) begin
          p = pend[k];
          fits = 1'b1;
          for (int j = 0; j < nres; j++) begin
            need = int'(claim_m[p][j]) - int'(alloc_m[p][j]);
            if (need > avail[j]) fits = 1'b0;
          end
          if (fits) begin
            for (int j = 0; j < nres; j++) avail[j] += int'(alloc_m[p][j]);
            r = '{proc_id: 4'(p), safe: 1'b1, last: 1'b0};
            found.push_back(r);
            moved = 1'b1;
          end else begin
            kept.push_back(p);
          end
        end
        pend = kept;
        if (!moved) begin
          r = '{proc_id: 4'd0, safe: 1'b0, last: 1'b1};
          found.push_back(r);
          unsafe_checks++;
          break;
        end
      end
      found[found.size()-1].last = 1'b1;
      foreach (found[k]) order_q.push_back(found[k]);
    endfunction

    function void note_item(in_t it);
      case (it.cmd)
        CMD_LOAD_TOTAL: begin
          total_m[it.res_index] = it.total_count;
          total_ok[it.res_index] = 1'b1;
        end
        CMD_LOAD_PROC: begin
          alloc_m[it.proc_index][it.res_index] = it.alloc_count;
          claim_m[it.proc_index][it.res_index] = it.max_count;
          entry_ok[it.proc_index][it.res_index] = 1'b1;
        end
        CMD_CHECK: find_safe_order();
        default: ;
      endcase
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (order_q.size() == 0) begin
        $error("unexpected result: proc_id=%0d safe=%0d last=%0d",
               got.proc_id, got.safe, got.last);
        errors++;
        return;
      end
      exp_r = order_q.pop_front();
      compared++;
      if (got.proc_id !== exp_r.proc_id) begin
        $error("proc_id: expected %0d, got %0d", exp_r.proc_id, got.proc_id);
        errors++;
      end
      if (got.safe !== exp_r.safe) begin
        $error("safe: expected %0d, got %0d", exp_r.safe, got.safe);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last: expected %0d, got %0d", exp_r.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_i = '0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic out_strobe_o;
  out_t result_o;

  safety_scoreboard sb = new();
  int items_sent = 0;
  int loads_sent = 0;
  int noise_sent = 0;
  int phases = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;
  int fixed_nr [6] = '{0, 2, 15, 8, 1, 8};
  int fixed_np [6] = '{0, 3, 31, 16, 16, 1};

  always #5 clk_i = ~clk_i;

  bankers_safety_check DUT (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .in_i,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .out_strobe_o,
    .result_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_strobe_o) sb.check_result(result_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || out_strobe_o || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("** bankers_safety_check: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_t rand_item(logic [1:0] cmd);
    logic [63:0] r;
    in_t it;
    r = {$urandom, $urandom};
    it = r[$bits(in_t)-1:0];
    it.cmd = cmd;
    return it;
  endfunction

  // start stays high across back-to-back transactions; it drops for a gap and in wait_idle
  task automatic drive_item(in_t it);
    int gap;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(it);
    if (it.cmd == CMD_NOP) noise_sent++;
    else items_sent++;
    if (it.cmd == CMD_LOAD_TOTAL || it.cmd == CMD_LOAD_PROC) loads_sent++;
  endtask

  task automatic send_total(int j, int val);
    in_t it;
    it = rand_item(CMD_LOAD_TOTAL);
    it.res_index = RES_W'(j);
    it.total_count = COUNT_BITS'(val);
    drive_item(it);
  endtask

  task automatic send_entry(int p, int j, int a, int c);
    in_t it;
    it = rand_item(CMD_LOAD_PROC);
    it.proc_index = PROC_W'(p);
    it.res_index = RES_W'(j);
    it.alloc_count = COUNT_BITS'(a);
    it.max_count = COUNT_BITS'(c);
    drive_item(it);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(logic [CFG_W-1:0] nr, logic [CFG_W-1:0] np);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_NUM_RES;
    cfg_data_i <= nr;
    @(posedge clk_i);
    sb.set_reg(CFG_NUM_RES, nr);
    cfg_index_i <= CFG_NUM_PROC;
    cfg_data_i <= np;
    @(posedge clk_i);
    sb.set_reg(CFG_NUM_PROC, np);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_entry_random(int p, int j, bit wide);
    int a;
    int c;
    if (wide) begin
      a = $urandom_range(0, 255);
      c = $urandom_range(0, 255);
    end else begin
      a = $urandom_range(0, 12);
      if ($urandom_range(0, 7) == 0) c = $urandom_range(0, a);
      else c = a + $urandom_range(0, 10);
    end
    send_entry(p, j, a, c);
  endtask

  // Refresh part of the in-use matrices and totals, then run a check.
  task automatic check_sequence();
    bit wide;
    int sum;
    int v;
    wide = ($urandom_range(0, 3) == 0);
    for (int p = 0; p < sb.nproc; p++) begin
      for (int j = 0; j < sb.nres; j++) begin
        if (!sb.entry_ok[p][j] || $urandom_range(0, 2) == 0) load_entry_random(p, j, wide);
        if ($urandom_range(0, 15) == 0) drive_item(rand_item(CMD_NOP));
        if ($urandom_range(0, 15) == 0)
          load_entry_random($urandom_range(0, MAX_PROCS-1), $urandom_range(0, MAX_RES-1), 1'b1);
      end
    end
    for (int j = 0; j < sb.nres; j++) begin
      if (!sb.total_ok[j] || $urandom_range(0, 1) == 0) begin
        sum = 0;
        for (int p = 0; p < sb.nproc; p++) sum += int'(sb.alloc_m[p][j]);
        if (wide || $urandom_range(0, 4) == 0) v = $urandom_range(0, 255);
        else if ($urandom_range(0, 5) == 0) v = (sum > 3) ? sum - 3 : 0;
        else v = sum + $urandom_range(0, 15);
        send_total(j, (v > 255) ? 255 : v);
      end
    end
    drive_item(rand_item(CMD_CHECK));
  endtask

  initial begin
    int nr_cfg;
    int np_cfg;
    int n_seq;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero need against zero availability
    send_entry(0, 0, 0, 0);
    send_total(0, 0);
    drive_item(rand_item(CMD_CHECK));
    // everything at full scale
    send_entry(0, 0, 255, 255);
    send_total(0, 255);
    drive_item(rand_item(CMD_CHECK));
    // need exceeds availability: unsafe
    send_entry(0, 0, 0, 255);
    send_total(0, 0);
    drive_item(rand_item(CMD_CHECK));
    // claim below allocation
    send_entry(0, 0, 10, 0);
    send_total(0, 20);
    drive_item(rand_item(CMD_CHECK));
    // negative need, but availability more negative
    send_entry(0, 0, 200, 10);
    send_total(0, 0);
    drive_item(rand_item(CMD_CHECK));
    drive_item(rand_item(CMD_NOP));
    send_total(MAX_RES-1, 8'hAA);
    send_entry(MAX_PROCS-1, MAX_RES-1, 8'h55, 8'hAA);
    send_total(MAX_RES-1, 8'h55);
    send_entry(MAX_PROCS-1, MAX_RES-1, 8'hAA, 8'h55);

    while (items_sent < 320) begin
      if (phases < 6) begin
        nr_cfg = fixed_nr[phases];
        np_cfg = fixed_np[phases];
      end else begin
        nr_cfg = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
        np_cfg = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
      end
      set_config(CFG_W'(nr_cfg), CFG_W'(np_cfg));
      gaps_on = ($urandom_range(0, 3) != 0);
      n_seq = (sb.nres * sb.nproc > 32) ? 1 : $urandom_range(1, 4);
      repeat (n_seq) check_sequence();
      phases++;
    end

    wait_idle();
    repeat (40) @(posedge clk_i);

    $display("covered %0d register settings, %0d loads, %0d ignored commands",
             phases, loads_sent, noise_sent);
    $display("%0d checks (%0d unsafe), %0d results compared",
             sb.checks, sb.unsafe_checks, sb.compared);
    if (sb.errors == 0) begin
      $display("** bankers_safety_check: PASSED **");
    end else begin
      $display("** bankers_safety_check: FAILED **");
    end
    $finish;
  end

endmodule
